/* rtl/bwtos_pkg.sv */
// shared types and codes for the bwt occurrence select block
package bwtos_pkg;

  // result status codes
  localparam logic [1:0] ST_FOUND     = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_LOADED    = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  // input function codes
  localparam logic FN_LOAD  = 1'b0;
  localparam logic FN_QUERY = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_COPY,
    S_BLK_RD,
    S_BLK_CHK,
    S_TXT_RD,
    S_TXT_CHK,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic       copy_step;
    logic       blk_read;
    logic       blk_adv;
    logic       txt_init;
    logic       txt_read;
    logic       txt_adv;
    logic       res_set;
    logic [1:0] res_code;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic is_load;
    logic full;
    logic miss;
    logic copy_last;
    logic blk_last;
    logic blk_hit;
    logic txt_end;
    logic txt_hit;
    logic out_busy;
  } sts_t;

endpackage

/* rtl/bwtos_ctrl.sv */
// controller state machine of the bwt occurrence select block
module bwtos_ctrl import bwtos_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:     if (in_valid) state_next = S_DISPATCH;
      S_DISPATCH: begin
        if (sts.is_load) state_next = sts.full ? S_EMIT : S_COPY;
        else             state_next = sts.miss ? S_EMIT : S_BLK_RD;
      end
      S_COPY:     if (sts.copy_last) state_next = S_EMIT;
      S_BLK_RD:   state_next = sts.blk_last ? S_TXT_RD : S_BLK_CHK;
      S_BLK_CHK:  state_next = sts.blk_hit ? S_TXT_RD : S_BLK_RD;
      S_TXT_RD:   state_next = sts.txt_end ? S_EMIT : S_TXT_CHK;
      S_TXT_CHK:  state_next = sts.txt_hit ? S_EMIT : S_TXT_RD;
      S_EMIT:     if (!sts.out_busy) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE:     in_ready = 1'b1;
      S_DISPATCH: begin
        if (sts.is_load && sts.full) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_FULL;
        end else if (!sts.is_load && sts.miss) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_NOT_FOUND;
        end
      end
      S_COPY: begin
        cmd.copy_step = 1'b1;
        if (sts.copy_last) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_LOADED;
        end
      end
      S_BLK_RD: begin
        if (sts.blk_last) cmd.txt_init = 1'b1;
        else              cmd.blk_read = 1'b1;
      end
      S_BLK_CHK: begin
        if (sts.blk_hit) cmd.txt_init = 1'b1;
        else             cmd.blk_adv  = 1'b1;
      end
      S_TXT_RD: begin
        if (sts.txt_end) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_NOT_FOUND;
        end else begin
          cmd.txt_read = 1'b1;
        end
      end
      S_TXT_CHK: begin
        if (sts.txt_hit) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_FOUND;
        end else begin
          cmd.txt_adv = 1'b1;
        end
      end
      S_EMIT:     cmd.emit = !sts.out_busy;
      default:    cmd = '0;
    endcase
  end

endmodule

/* rtl/bwtos_dp.sv */
// datapath of the bwt occurrence select block: stores, counters, result register
module bwtos_dp import bwtos_pkg::*; #(
  parameter int MAX_LENGTH = 4096,
  parameter int BLOCK_SIZE = 64,
  parameter int ALPHABET   = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_take,
  input  logic        func,
  input  logic [2:0]  symbol,
  input  logic [12:0] rank_wanted,
  input  cmd_t        cmd,
  output sts_t        sts,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [12:0] position,
  output logic [1:0]  status
);

  localparam int NUM_BLOCKS = (MAX_LENGTH + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam int LW   = $clog2(MAX_LENGTH + 1);
  localparam int TW   = $clog2(MAX_LENGTH);
  localparam int CW   = LW;
  localparam int CMPW = (CW > 13) ? CW : 13;
  localparam int BW   = $clog2(NUM_BLOCKS + 1);
  localparam int OW   = $clog2(BLOCK_SIZE + 1);
  localparam int AW   = $clog2(ALPHABET);
  localparam int BAW  = $clog2(NUM_BLOCKS * ALPHABET);

  function automatic logic [2:0] reduce_sym(input logic [2:0] s);
    logic [2:0] v;
    v = s;
    for (int k = 0; k < 4; k++) begin
      if ({29'd0, v} >= ALPHABET) v = v - 3'(ALPHABET);
    end
    return v;
  endfunction

  logic [2:0]    text_mem [MAX_LENGTH];
  logic [CW-1:0] bt_mem   [NUM_BLOCKS * ALPHABET];
  logic [CW-1:0] running  [ALPHABET];

  logic [LW-1:0] len;
  logic [BW-1:0] len_blk;
  logic [OW-1:0] len_off;
  logic          func_r;
  logic [2:0]    sym_r;
  logic [12:0]   n_r;
  logic          full_r, miss_r;
  logic [BW-1:0] blk_w;
  logic [AW-1:0] copy_idx;
  logic [BW-1:0] b;
  logic [CW-1:0] prev, btq, cnt;
  logic [LW-1:0] i;
  logic [OW-1:0] j;
  logic [2:0]    tq;
  logic [12:0]   res_pos;
  logic [1:0]    res_st;

  logic [2:0]    sym_in;
  logic          full_now, load_go;
  logic [BW-1:0] nblocks;

  assign sym_in   = reduce_sym(symbol);
  assign full_now = (len == LW'(MAX_LENGTH));
  assign load_go  = in_take && (func == FN_LOAD) && !full_now;
  assign nblocks  = len_blk + BW'(len_off != '0);

  // append and running counts
  always_ff @(posedge clk) begin
    if (rst) begin
      len     <= '0;
      len_blk <= '0;
      len_off <= '0;
      for (int a = 0; a < ALPHABET; a++) running[a] <= '0;
    end else if (load_go) begin
      len <= len + LW'(1);
      running[AW'(sym_in)] <= running[AW'(sym_in)] + CW'(1);
      if (len_off == OW'(BLOCK_SIZE - 1)) begin
        len_off <= '0;
        len_blk <= len_blk + BW'(1);
      end else begin
        len_off <= len_off + OW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_go) text_mem[len[TW-1:0]] <= sym_in;
    if (cmd.txt_read) tq <= text_mem[i[TW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.copy_step) bt_mem[BAW'(blk_w * ALPHABET + copy_idx)] <= running[copy_idx];
    if (cmd.blk_read) btq <= bt_mem[BAW'(b * ALPHABET + sym_r)];
  end

  // item latch and query walk
  always_ff @(posedge clk) begin
    if (in_take) begin
      func_r   <= func;
      sym_r    <= sym_in;
      n_r      <= rank_wanted;
      full_r   <= full_now;
      miss_r   <= (rank_wanted == '0) ||
                  (CMPW'(rank_wanted) > CMPW'(running[AW'(sym_in)]));
      blk_w    <= len_blk;
      copy_idx <= '0;
      b        <= '0;
      prev     <= '0;
    end
    if (cmd.copy_step) copy_idx <= copy_idx + AW'(1);
    if (cmd.blk_adv) begin
      prev <= btq;
      b    <= b + BW'(1);
    end
    if (cmd.txt_init) begin
      i   <= LW'(b * BLOCK_SIZE);
      j   <= '0;
      cnt <= prev;
    end
    if (cmd.txt_adv) begin
      if (tq == sym_r) cnt <= cnt + CW'(1);
      i <= i + LW'(1);
      j <= j + OW'(1);
    end
    if (cmd.res_set) begin
      res_st  <= cmd.res_code;
      res_pos <= (cmd.res_code == ST_FOUND) ? 13'(i + LW'(1)) : 13'd0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      position <= res_pos;
      status   <= res_st;
    end
  end

  always_comb begin
    sts.is_load   = (func_r == FN_LOAD);
    sts.full      = full_r;
    sts.miss      = miss_r;
    sts.copy_last = (copy_idx == AW'(ALPHABET - 1));
    sts.blk_last  = ((b + BW'(1)) >= nblocks);
    sts.blk_hit   = (CMPW'(btq) >= CMPW'(n_r));
    sts.txt_end   = (j == OW'(BLOCK_SIZE)) || (i >= len);
    sts.txt_hit   = (tq == sym_r) && (CMPW'(cnt + CW'(1)) == CMPW'(n_r));
    sts.out_busy  = out_valid && !out_ready;
  end

endmodule

/* rtl/bwt_occurrence_select.sv */
// top level of the bwt sampled occurrence select block
// stores a text of symbol codes with per-block cumulative symbol counts and
// answers select queries. on a load the whole count row of the current block
// is rewritten one symbol a cycle through the single write port of the count
// memory. a load into a full store skips the copy and answers with the full
// status. a query walks the block counts, then scans the stored symbols of
// one block; each block count checked and each stored symbol takes one memory
// read and one compare step. a query with a zero rank or a rank above the
// symbol total is answered without a walk. one item is in work at a time; the
// result sits in an output register, so the next item is taken while an
// earlier result still waits for its transfer.
module bwt_occurrence_select import bwtos_pkg::*; #(
  parameter int MAX_LENGTH = 4096,
  parameter int BLOCK_SIZE = 64,
  parameter int ALPHABET   = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [2:0]  symbol,
  input  logic [12:0] rank_wanted,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [12:0] position,
  output logic [1:0]  status
);

  cmd_t cmd;
  sts_t sts;

  // controller: sequences load copy, block walk and text scan
  bwtos_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: text and count memories, walk counters, result register
  bwtos_dp #(
    .MAX_LENGTH (MAX_LENGTH),
    .BLOCK_SIZE (BLOCK_SIZE),
    .ALPHABET   (ALPHABET)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .in_take     (in_valid && in_ready),
    .func        (func),
    .symbol      (symbol),
    .rank_wanted (rank_wanted),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .position    (position),
    .status      (status)
  );

endmodule

/* rtl/bwtos_check.sv */
// port checker for the bwt occurrence select block, with its bind
module bwtos_check import bwtos_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [12:0] position,
  input logic [1:0]  status
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(position) && $stable(status))
    else $error("result changed while stalled");

  a_load_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_LOADED || status == ST_FULL) |-> position == 13'd0)
    else $error("load result with nonzero position");

  a_miss_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_NOT_FOUND |-> position == 13'd0)
    else $error("not-found result with nonzero position");

  a_found_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FOUND |-> position != 13'd0)
    else $error("found result with zero position");

endmodule

bind bwt_occurrence_select bwtos_check u_check (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .position  (position),
  .status    (status)
);

/* tb/bwt_occurrence_select_tb.sv */
// testbench for the bwt occurrence select block
module tb;
  import bwtos_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LEN = 4096;
  localparam int BLK     = 64;
  localparam int NSYM    = 8;
  localparam int NBLK    = MAX_LEN / BLK;

  // one expected answer
  typedef struct {
    logic [12:0] position;
    logic [1:0]  status;
  } answer_t;

  // shadow of the block state plus the queue of expected answers
  class select_scoreboard;
    logic [2:0]  text[MAX_LEN];
    logic [12:0] row_totals[NBLK][NSYM];
    logic [12:0] sym_totals[NSYM];
    int          length;
    answer_t     pending[$];
    int          errors;

    function new();
      length = 0;
      errors = 0;
      foreach (sym_totals[s]) sym_totals[s] = '0;
    endfunction

    // predict the answer for one transferred input item
    function void note_input(logic fn, logic [2:0] sym, logic [12:0] n);
      answer_t a;
      int nblocks, b, cnt, stop;
      a.position = '0;
      if (fn == FN_LOAD) begin
        if (length >= MAX_LEN) begin
          a.status = ST_FULL;
        end else begin
          text[length] = sym;
          sym_totals[sym]++;
          for (int s = 0; s < NSYM; s++) row_totals[length / BLK][s] = sym_totals[s];
          length++;
          a.status = ST_LOADED;
        end
      end else if (n == 0 || n > sym_totals[sym]) begin
        a.status = ST_NOT_FOUND;
      end else begin
        nblocks = (length + BLK - 1) / BLK;
        b = 0;
        while (b + 1 < nblocks && row_totals[b][sym] < n) b++;
        // scan starts from the previous block's total
        cnt = (b == 0) ? 0 : row_totals[b - 1][sym];
        stop = (b * BLK + BLK > length) ? length : b * BLK + BLK;
        a.status = ST_NOT_FOUND;
        for (int i = b * BLK; i < stop; i++) begin
          if (text[i] == sym) begin
            cnt++;
            if (cnt == n && a.status != ST_FOUND) begin
              a.position = 13'(i + 1);
              a.status = ST_FOUND;
            end
          end
        end
      end
      pending = {pending, a};
    endfunction

    function void check_result(logic [12:0] pos, logic [1:0] st);
      answer_t a;
      if (pending.size() == 0) begin
        $error("unexpected result position=%0d status=%0d", pos, st);
        errors++;
        return;
      end
      a = pending.pop_front();
      if (pos !== a.position) begin
        $error("position expected %0d actual %0d", a.position, pos);
        errors++;
      end
      if (st !== a.status) begin
        $error("status expected %0d actual %0d", a.status, st);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        func = 1'b0;
  logic [2:0]  symbol = '0;
  logic [12:0] rank_wanted = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [12:0] position;
  logic [1:0]  status;

  select_scoreboard sb = new();
  int send_idle_pct = 0;   // chance in a hundred that the sender idles
  int recv_idle_pct = 0;   // chance in a hundred that the receiver idles
  int hold_off      = 0;   // cycles of forced receiver hold-off still to run

  bwt_occurrence_select u_dut (
    .clk, .rst, .in_valid, .in_ready, .func, .symbol, .rank_wanted,
    .out_valid, .out_ready, .position, .status
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // watchdog against a hung run
  initial begin
    #200ms;
    $display("Verification failed");
    $finish;
  end

  // receiver side: random stalls plus the long forced hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) sb.check_result(position, status);
      if (hold_off > 0) begin
        hold_off  <= hold_off - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // offer one item and wait for its transfer; valid stays high across items unless the sender idles
  task automatic send_item(logic fn, logic [2:0] sym, logic [12:0] n);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    func        <= fn;
    symbol      <= sym;
    rank_wanted <= n;
    do @(posedge clk); while (!in_ready);
    sb.note_input(fn, sym, n);
  endtask

  // rank picked mostly near the live totals so that queries hit
  function automatic logic [12:0] pick_rank(logic [2:0] sym);
    int r;
    r = $urandom_range(99);
    if (r < 80) return 13'($urandom_range(sb.sym_totals[sym] + 1));
    if (r < 90) return 13'($urandom_range(8191));
    return (r < 95) ? 13'd0 : 13'd4096;
  endfunction

  task automatic random_phase(int items, int load_pct);
    logic [2:0] s;
    repeat (items) begin
      s = 3'($urandom_range(7));
      if ($urandom_range(99) < load_pct) send_item(FN_LOAD, s, 13'($urandom_range(8191)));
      else send_item(FN_QUERY, s, pick_rank(s));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty-text queries, then a short text and edge ranks
    send_item(FN_QUERY, 3'd0, 13'd1);
    send_item(FN_QUERY, 3'd7, 13'd0);
    send_item(FN_LOAD, 3'd7, 13'h1fff);
    send_item(FN_LOAD, 3'd0, 13'd0);
    send_item(FN_LOAD, 3'd7, 13'd0);
    send_item(FN_QUERY, 3'd7, 13'd1);
    send_item(FN_QUERY, 3'd7, 13'd2);
    send_item(FN_QUERY, 3'd7, 13'd3);
    send_item(FN_QUERY, 3'd0, 13'd0);
    send_item(FN_QUERY, 3'd0, 13'h1fff);
    send_item(FN_QUERY, 3'd5, 13'd4096);

    // sender idles 20 %, receiver 74 %
    send_idle_pct = 20;
    recv_idle_pct = 74;
    random_phase(250, 70);

    // long receiver hold-off while items keep coming, to back up the input
    hold_off = 300;
    random_phase(40, 50);

    send_idle_pct = 74;
    recv_idle_pct = 20;
    random_phase(250, 60);

    // no idling: mostly loads so the text spans many blocks
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(246, 90);
    // loads with odd ranks, then queries over the longer text
    send_item(FN_LOAD, 3'd3, 13'd0);
    send_item(FN_LOAD, 3'd7, 13'h1fff);
    send_item(FN_QUERY, 3'd1, 13'd4096);
    random_phase(250, 20);

    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
